// File: rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// Shared widths, constants and types of the radix digit extractor.
// ----------------------------------------------------------------------------
package rde_pkg;

   localparam int VALUE_BITS_DEF  = 31;
   localparam int MAX_DIGITS_DEF  = 31;

   localparam int RADIX_BITS      = 6;
   localparam int DIGIT_BITS      = 6;
   localparam int DIGIT_POS_BITS  = 5;
   localparam int RSP_DATA_BITS   = 16;

   // Quotient bits the divider resolves in one cycle.
   localparam int STEP_BITS       = 8;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;

   typedef struct packed {
      logic done;
      logic quot_zero;
   } div_stat_type;

endpackage

// File: rtl/radix_digit_extractor_core.sv
// ----------------------------------------------------------------------------
// radix_digit_extractor_core
// Splits a non-negative integer into digits of a configured base, least
// significant digit first, one result item per digit.
// ----------------------------------------------------------------------------
// Each digit takes the divider passes (one per eight value bits), then the
// sequencer sees the registered done flag and loads the output register.
// The first division starts as the item is accepted; the block takes no
// new item until the last digit of the current one is loaded.
// A stalled output register holds the sequencer until the digit is taken.
// Reset (synchronous, active high) sets the radix to 10 and empties the output.
module radix_digit_extractor_core #(
   parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = rde_pkg::MAX_DIGITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // value
   input  logic [((VALUE_BITS+7)/8)*8-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // digit, digit_position
   output logic [rde_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rde_pkg::RADIX_BITS-1:0]    csr_data
);

   localparam int POS_W = $clog2(MAX_DIGITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type                          state_ff, state_in;
   logic [rde_pkg::RADIX_BITS-1:0]     radix_ff, radix_in;
   logic [POS_W-1:0]                   pos_ff, pos_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rde_pkg::DIGIT_BITS-1:0]     rsp_digit_ff, rsp_digit_in;
   logic [rde_pkg::DIGIT_POS_BITS-1:0] rsp_pos_ff, rsp_pos_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [rde_pkg::RADIX_BITS-1:0]     radix_eff;
   logic                               div_start;
   logic [VALUE_BITS-1:0]              div_dividend;
   logic [VALUE_BITS-1:0]              div_quot;
   logic [rde_pkg::RADIX_BITS-1:0]     div_rem;
   rde_pkg::div_stat_type              div_stat;
   logic                               req_take;
   logic                               load_rsp;
   logic                               last_digit;

   always_comb begin
      if (radix_ff < rde_pkg::RADIX_MIN) begin
         radix_eff = rde_pkg::RADIX_MIN;
      end else if (radix_ff > rde_pkg::RADIX_MAX) begin
         radix_eff = rde_pkg::RADIX_MAX;
      end else begin
         radix_eff = radix_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_take   = req_tvalid && req_tready;
   assign last_digit = div_stat.quot_zero || (pos_ff == POS_W'(MAX_DIGITS - 1));
   assign load_rsp   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // The next division starts either on a new item or on the previous quotient.
   assign div_start    = req_take || (load_rsp && !last_digit);
   assign div_dividend = req_take ? req_tdata[VALUE_BITS-1:0] : div_quot;

   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_digit_in = rsp_digit_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      if (csr_valid && csr_ready) begin
         radix_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               pos_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = div_rem;
               rsp_pos_in   = rde_pkg::DIGIT_POS_BITS'(pos_ff);
               rsp_last_in  = last_digit;
               if (last_digit) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= rde_pkg::RADIX_RESET;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
      rsp_digit_ff <= rsp_digit_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   rde_div_unit #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (radix_eff),
      .quotient  (div_quot),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(rde_pkg::RSP_DATA_BITS - rde_pkg::DIGIT_POS_BITS
                          - rde_pkg::DIGIT_BITS){1'b0}}, rsp_pos_ff, rsp_digit_ff};

`ifndef SYNTHESIS
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("division finished outside of the divide state");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_DIV))
      else $error("accepted item did not start a division");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && last_digit) |=> (state_ff == ST_IDLE) && rsp_tvalid && rsp_tlast)
      else $error("last digit did not end the run");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (pos_ff < POS_W'(MAX_DIGITS)))
      else $error("digit position beyond the digit limit");
`endif

endmodule

// File: rtl/rde_div_unit.sv
// ----------------------------------------------------------------------------
// rde_div_unit
// Iterative restoring divider of a wide dividend by a small radix. The
// dividend sits in a shift register that fills up with quotient bits, eight
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module rde_div_unit #(
   parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [VALUE_BITS-1:0]          dividend,
   input  logic [rde_pkg::RADIX_BITS-1:0] divisor,
   output logic [VALUE_BITS-1:0]          quotient,
   output logic [rde_pkg::RADIX_BITS-1:0] remainder,
   output rde_pkg::div_stat_type          stat
);

   localparam int PASSES   = (VALUE_BITS + rde_pkg::STEP_BITS - 1) / rde_pkg::STEP_BITS;
   localparam int PAD_BITS = PASSES * rde_pkg::STEP_BITS;
   localparam int CNT_W    = $clog2(PASSES + 1);

   logic [PAD_BITS-1:0]            work_ff, work_in;
   logic [rde_pkg::RADIX_BITS-1:0] rem_ff, rem_in;
   logic [rde_pkg::RADIX_BITS-1:0] div_ff, div_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;

   logic [rde_pkg::STEP_BITS-1:0]  step_q;
   logic [rde_pkg::RADIX_BITS-1:0] step_rem;

   // Eight dependent compare-and-subtract steps on a 7-bit partial remainder.
   always_comb begin
      logic [rde_pkg::RADIX_BITS:0]   part;
      logic [rde_pkg::RADIX_BITS-1:0] r;
      logic [rde_pkg::STEP_BITS-1:0]  top;
      r      = rem_ff;
      top    = work_ff[PAD_BITS-1 -: rde_pkg::STEP_BITS];
      step_q = '0;
      for (int i = rde_pkg::STEP_BITS - 1; i >= 0; i--) begin
         part = {r, top[i]};
         if (part >= {1'b0, div_ff}) begin
            part      = part - {1'b0, div_ff};
            step_q[i] = 1'b1;
         end
         r = part[rde_pkg::RADIX_BITS-1:0];
      end
      step_rem = r;
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = PAD_BITS'(dividend);
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         work_in = (work_ff << rde_pkg::STEP_BITS) | PAD_BITS'(step_q);
         rem_in  = step_rem;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(PASSES - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign quotient       = work_ff[VALUE_BITS-1:0];
   assign remainder      = rem_ff;
   assign stat.done      = done_ff;
   assign stat.quot_zero = (work_ff[VALUE_BITS-1:0] == '0);

`ifndef SYNTHESIS
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("divider done without a running division");

   a_run_count: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (cnt_ff < CNT_W'(PASSES)))
      else $error("divider pass counter out of range");
`endif

endmodule
